// ===== sv/rjsc_pkg.sv =====
// Shared types and constants of the RTP jitter slot controller.
package rjsc_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_RESET_GAP = 2'd0;
  localparam logic [1:0] CFG_LOST_WAIT = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN   = 2'd2;

  localparam logic [15:0] RESET_GAP_DEFAULT = 16'd1000;
  localparam logic [15:0] LOST_WAIT_DEFAULT = 16'd200;
  localparam logic [10:0] MAX_LEN_DEFAULT   = 11'd1400;

  // Lengths at or below this are runts
  localparam logic [10:0] MIN_LEN_EXCL = 11'd12;

  // Sequence mark meaning "no sequence seen yet"
  localparam logic [16:0] SEQ_NONE = 17'h10000;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_GAP      = 3'd1,
    ST_DISORDER = 3'd2,
    ST_BADLEN   = 3'd3,
    ST_NOTHING  = 3'd4,
    ST_LOST     = 3'd5
  } status_e;

  typedef struct packed {
    logic        opcode;
    logic [15:0] seq_number;
    logic [10:0] packet_length_in;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  slot_index;
    logic [10:0] packet_length;
    logic [15:0] read_seq;
    logic [15:0] lost_first;
    logic [15:0] lost_last;
    logic [31:0] lost_total;
    logic        buffer_reset;
    logic [31:0] packets_stored;
    logic [31:0] bytes_stored;
  } out_t;

endpackage

// ===== sv/rjsc_slot_mod.sv =====
// Sequence to slot reduction: value mod SLOT_COUNT by reciprocal multiply.
module rjsc_slot_mod #(
  parameter int SLOT_COUNT = 256
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic [15:0]                   value_i,
  output logic [$clog2(SLOT_COUNT)-1:0] slot_o
);

  localparam int          SLOT_W = $clog2(SLOT_COUNT);
  localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / SLOT_COUNT);
  localparam logic [31:0] DIVISOR = 32'(SLOT_COUNT);

  logic [15:0] value_q;
  logic [47:0] prod_q;
  logic [15:0] quot;
  logic [31:0] qn;
  logic [31:0] rem_raw;
  logic [31:0] rem_fix;

  // Stage 1: quotient estimate, exact or one short
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q <= value_i;
      prod_q  <= 48'(value_i) * 48'(RECIP);
    end
  end

  // Stage 2: remainder with one correction step
  always_comb begin
    quot    = prod_q[47:32];
    qn      = 32'(quot) * DIVISOR;
    rem_raw = 32'(value_q) - qn;
    rem_fix = (rem_raw >= DIVISOR) ? rem_raw - DIVISOR : rem_raw;
    slot_o  = SLOT_W'(rem_fix);
  end

endmodule

// ===== sv/rtp_jitter_slot_controller.sv =====
// Top level of the RTP jitter slot controller: slot table, sequence state, result beat.
//
// Slot controller of an RTP jitter buffer. A write beat (opcode 0) stores the
// packet length in slot seq mod SLOT_COUNT, marks it ready and classifies the
// sequence (in order, gap with its lost range, disorder, or bad length); a
// write arriving more than reset_gap_ms after the previous one first wipes all
// slots, both sequence marks, the read time and the counters. A read beat
// (opcode 1) hands out the slot of the next sequence once ready, or after
// lost_wait_ms skips it as lost. Every input beat gives exactly one result
// beat. An item's steps are: the accepting edge captures it, then the
// quotient multiply of the slot reduction, the remainder and slot memory read,
// and the read-modify-write of the slot memory and sequence state. The result
// is written into the output register on commit, after which the block is idle
// again and can accept the next item. Only one item is in flight; a new item is
// accepted while the last result still waits in the output register, and the
// final stage stalls until that register is free. Ready bits and lengths share
// one single-port style synchronous memory with a registered read; a
// written-since-wipe flop per slot gates both, so reset and a buffer wipe take
// effect at once with no clearing pass.
module rtp_jitter_slot_controller #(
  parameter int SLOT_COUNT  = 256,
  parameter int LENGTH_BITS = 11
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rjsc_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rjsc_pkg::out_t out_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_RED  = 4'b0100,
    S_EXEC = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [15:0] reset_gap_q, lost_wait_q;
  logic [10:0] max_len_q;

  // Item in flight and per-item precomputed flags
  rjsc_pkg::in_t     item_q;
  logic              has_cur_q;
  logic [15:0]       cur_q;
  logic [SLOT_W-1:0] slot_q;
  logic              bad_q;
  logic              reinit_q;
  logic              expire_q;

  // Sequence state
  logic [16:0] lws_q, lws_d;
  logic [16:0] lrs_q, lrs_d;
  logic [31:0] lwt_q, lwt_d;
  logic [31:0] lrt_q, lrt_d;
  logic [31:0] lost_q, lost_d;
  logic [31:0] pkt_q, pkt_d;
  logic [31:0] byt_q, byt_d;
  logic [31:0] gap_q, gap_d;

  logic [SLOT_COUNT-1:0] lvalid_q, lvalid_d;

  // Slot memory: {ready, length}
  logic [LENGTH_BITS:0] len_mem [SLOT_COUNT];
  logic [LENGTH_BITS:0] rdata_q;
  logic [LENGTH_BITS:0] mem_wdata;
  logic                 mem_we;
  logic                 slot_ready;

  // Output register
  logic           out_valid_q;
  rjsc_pkg::out_t out_q, res;

  logic              commit;
  logic              take;
  logic              cur_has;
  logic [15:0]       cur_seq;
  logic [15:0]       mod_value;
  logic [SLOT_W-1:0] mod_slot;
  logic [31:0]       lwt_eff;
  logic [16:0]       prev_seq;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign commit      = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  // Ready only counts for slots written since the last wipe
  assign slot_ready  = lvalid_q[slot_q] && rdata_q[LENGTH_BITS];

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_gap_q <= rjsc_pkg::RESET_GAP_DEFAULT;
      lost_wait_q <= rjsc_pkg::LOST_WAIT_DEFAULT;
      max_len_q   <= rjsc_pkg::MAX_LEN_DEFAULT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rjsc_pkg::CFG_RESET_GAP: reset_gap_q <= cfg_data_i;
        rjsc_pkg::CFG_LOST_WAIT: lost_wait_q <= cfg_data_i;
        rjsc_pkg::CFG_MAX_LEN:   max_len_q   <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Next read sequence: one past the last read, or the last written if no
  // read yet; none when the reader has caught up.
  // ---------------------------------------------------------------------------
  always_comb begin
    cur_has = 1'b0;
    cur_seq = '0;
    if (lws_q != lrs_q) begin
      if (!lrs_q[16]) begin
        cur_has = 1'b1;
        cur_seq = lrs_q[15:0] + 16'd1;
      end else if (!lws_q[16]) begin
        cur_has = 1'b1;
        cur_seq = lws_q[15:0];
      end
    end
  end

  assign mod_value = (item_q.opcode == rjsc_pkg::OP_READ) ? cur_seq : item_q.seq_number;

  rjsc_slot_mod #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slot_mod (
    .clk_i   (clk_i),
    .load_i  (state_q == S_MOD),
    .value_i (mod_value),
    .slot_o  (mod_slot)
  );

  // Write time of zero means unset: take this beat's time instead
  assign lwt_eff = (lwt_q == 32'd0) ? item_q.now_ms : lwt_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MOD;
      S_MOD:  state_d = S_RED;
      S_RED:  state_d = S_EXEC;
      S_EXEC: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_i;
    end
    if (state_q == S_MOD) begin
      has_cur_q <= cur_has;
      cur_q     <= cur_seq;
    end
    if (state_q == S_RED) begin
      slot_q   <= mod_slot;
      bad_q    <= (item_q.packet_length_in <= rjsc_pkg::MIN_LEN_EXCL) ||
                  (item_q.packet_length_in > max_len_q);
      reinit_q <= (item_q.now_ms - lwt_eff) > {16'd0, reset_gap_q};
      expire_q <= (item_q.now_ms - lrt_q) > {16'd0, lost_wait_q};
    end
  end

  // Slot memory: read issued with the slot, written on commit
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      len_mem[slot_q] <= mem_wdata;
    end
    if (state_q == S_RED) begin
      rdata_q <= len_mem[mod_slot];
    end
  end

  // ---------------------------------------------------------------------------
  // Read-modify-write of the slot table and sequence state
  // ---------------------------------------------------------------------------
  always_comb begin
    lws_d     = lws_q;
    lrs_d     = lrs_q;
    lwt_d     = lwt_q;
    lrt_d     = lrt_q;
    lost_d    = lost_q;
    pkt_d     = pkt_q;
    byt_d     = byt_q;
    gap_d     = gap_q;
    lvalid_d  = lvalid_q;
    mem_we    = 1'b0;
    mem_wdata = '0;
    take      = 1'b0;
    prev_seq  = lws_q;
    res       = '0;
    res.status = rjsc_pkg::ST_NOTHING;

    if (commit) begin
      if (item_q.opcode == rjsc_pkg::OP_WRITE) begin
        res.status = rjsc_pkg::ST_OK;
        if (bad_q) begin
          res.status = rjsc_pkg::ST_BADLEN;
        end else begin
          if (reinit_q) begin
            // long write silence: wipe the buffer, keep config and gap range
            lvalid_d = '0;
            lws_d    = rjsc_pkg::SEQ_NONE;
            lrs_d    = rjsc_pkg::SEQ_NONE;
            lrt_d    = '0;
            lost_d   = '0;
            pkt_d    = '0;
            byt_d    = '0;
          end
          prev_seq          = lws_d;
          lvalid_d[slot_q]  = 1'b1;
          mem_we            = 1'b1;
          mem_wdata         = {1'b1, LENGTH_BITS'(item_q.packet_length_in)};
          res.buffer_reset  = reinit_q;
          res.slot_index    = 8'(slot_q);
          res.packet_length = item_q.packet_length_in;
          // in order, first write, or 16-bit wrap are all fine
          if (!prev_seq[16] && ({1'b0, item_q.seq_number} != prev_seq + 17'd1) &&
              !((prev_seq == 17'h0FFFF) && (item_q.seq_number == 16'd0))) begin
            if ({1'b0, item_q.seq_number} > prev_seq) begin
              gap_d      = {prev_seq[15:0] + 16'd1, item_q.seq_number - 16'd1};
              res.status = rjsc_pkg::ST_GAP;
            end else begin
              res.status = rjsc_pkg::ST_DISORDER;
            end
          end
          lws_d = {1'b0, item_q.seq_number};
          lwt_d = item_q.now_ms;
          byt_d = byt_d + 32'(item_q.packet_length_in);
          pkt_d = pkt_d + 32'd1;
        end
      end else if (has_cur_q) begin
        if (slot_ready) begin
          take       = 1'b1;
          lrt_d      = item_q.now_ms;
          res.status = rjsc_pkg::ST_OK;
        end else if (expire_q) begin
          // waited too long: skip the slot, read time stays
          take       = 1'b1;
          if (lost_q != 32'hFFFF_FFFF) lost_d = lost_q + 32'd1;
          res.status = rjsc_pkg::ST_LOST;
        end
        if (take) begin
          res.slot_index    = 8'(slot_q);
          res.packet_length = lvalid_q[slot_q] ? 11'(rdata_q[LENGTH_BITS-1:0]) : 11'd0;
          res.read_seq      = cur_q;
          // clear ready, keep the length for a later skip
          mem_we            = 1'b1;
          mem_wdata         = {1'b0, rdata_q[LENGTH_BITS-1:0]};
          lrs_d             = {1'b0, cur_q};
        end
      end
      res.lost_first     = gap_d[31:16];
      res.lost_last      = gap_d[15:0];
      res.lost_total     = lost_d;
      res.packets_stored = pkt_d;
      res.bytes_stored   = byt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      lws_q       <= rjsc_pkg::SEQ_NONE;
      lrs_q       <= rjsc_pkg::SEQ_NONE;
      lwt_q       <= '0;
      lrt_q       <= '0;
      lost_q      <= '0;
      pkt_q       <= '0;
      byt_q       <= '0;
      gap_q       <= '0;
      lvalid_q    <= '0;
    end else begin
      state_q  <= state_d;
      lws_q    <= lws_d;
      lrs_q    <= lrs_d;
      lwt_q    <= lwt_d;
      lrt_q    <= lrt_d;
      lost_q   <= lost_d;
      pkt_q    <= pkt_d;
      byt_q    <= byt_d;
      gap_q    <= gap_d;
      lvalid_q <= lvalid_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // A new result beat only appears right after the update stage
  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result beat raised outside the update stage");

  // Reads only answer ok, nothing or lost
  a_read_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (item_q.opcode == rjsc_pkg::OP_READ) |->
      (res.status == rjsc_pkg::ST_OK) || (res.status == rjsc_pkg::ST_NOTHING) ||
      (res.status == rjsc_pkg::ST_LOST))
    else $error("read produced a write status");

  // A consumed slot moves the read mark to its sequence
  a_take_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && take |=> lrs_q == {1'b0, $past(cur_q)})
    else $error("taken slot did not advance the read mark");

  // Lost count only drops on a buffer wipe
  a_lost_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && !(item_q.opcode == rjsc_pkg::OP_WRITE && !bad_q && reinit_q) |=>
      lost_q >= $past(lost_q))
    else $error("lost counter decreased without a wipe");

endmodule

// ===== tb/sv/tb_rtp_jitter_slot_controller.sv =====
// Self-checking testbench of the RTP jitter slot controller: directed and random beats.
module tb_rtp_jitter_slot_controller;
  timeunit 1ns;
  timeprecision 1ps;

  // Timeout, far beyond the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          SLOTS       = 256;

  // ---------------------------------------------------------------------------
  // DUT connections. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic           clk;
  logic           rst_n       = 1'b0;
  logic           in_valid    = 1'b0;
  logic           in_ready;
  rjsc_pkg::in_t  in_data     = '0;
  logic           out_valid;
  logic           out_ready   = 1'b0;
  rjsc_pkg::out_t out_data;
  logic           cfg_we      = 1'b0;
  logic [1:0]     cfg_index   = rjsc_pkg::CFG_RESET_GAP;
  logic [15:0]    cfg_data    = '0;

  rtp_jitter_slot_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the slot controller: slot table, sequence marks, times, counters,
  // and the three limits as last programmed.
  // ---------------------------------------------------------------------------
  logic        slot_full [SLOTS];
  logic [10:0] slot_len  [SLOTS];
  logic [16:0] wr_mark, rd_mark;
  logic [31:0] wr_time, rd_time;
  logic [31:0] lost_cnt, pkt_cnt, byte_cnt;
  logic [31:0] gap_span;          // first missing seq high, last missing seq low
  logic [15:0] gap_limit, wait_limit;
  logic [10:0] len_limit;

  rjsc_pkg::out_t slot_results_due[$];   // predicted result beats, oldest first
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count    = 0;
  bit             no_idle        = 1'b0; // stretch with back-to-back beats on both sides

  // Buffer wipe: keeps the limits and the last gap range.
  function automatic void wipe_slot_model();
    for (int i = 0; i < SLOTS; i++) begin
      slot_full[i] = 1'b0;
      slot_len[i]  = '0;
    end
    wr_mark  = rjsc_pkg::SEQ_NONE;
    rd_mark  = rjsc_pkg::SEQ_NONE;
    wr_time  = '0;
    rd_time  = '0;
    lost_cnt = '0;
    pkt_cnt  = '0;
    byte_cnt = '0;
  endfunction

  // Applies one input beat to the shadow and returns the result beat it gives.
  function automatic rjsc_pkg::out_t compute_slot_result(rjsc_pkg::in_t beat);
    rjsc_pkg::out_t res;
    logic [16:0]    cur;
    logic [16:0]    seq17;
    logic [7:0]     pos;
    logic           take;
    res        = '0;
    res.status = rjsc_pkg::ST_OK;
    if (beat.opcode == rjsc_pkg::OP_WRITE) begin
      if (beat.packet_length_in <= rjsc_pkg::MIN_LEN_EXCL ||
          beat.packet_length_in > len_limit) begin
        res.status = rjsc_pkg::ST_BADLEN;   // runt or oversize: nothing changes
      end else begin
        // Zero write time means unset; a write at time zero keeps it unset.
        if (wr_time == 32'd0) wr_time = beat.now_ms;
        if ((beat.now_ms - wr_time) > 32'(gap_limit)) begin
          wipe_slot_model();
          res.buffer_reset = 1'b1;
        end
        pos                = beat.seq_number[7:0];
        slot_full[pos]     = 1'b1;
        slot_len[pos]      = beat.packet_length_in;
        res.slot_index     = pos;
        res.packet_length  = beat.packet_length_in;
        seq17              = {1'b0, beat.seq_number};
        // In order, first write, or 0xFFFF -> 0 wrap all count as ok.
        if (wr_mark != rjsc_pkg::SEQ_NONE && seq17 != wr_mark + 17'd1 &&
            !(wr_mark == 17'h0FFFF && beat.seq_number == 16'd0)) begin
          if (seq17 > wr_mark) begin
            gap_span   = {wr_mark[15:0] + 16'd1, beat.seq_number - 16'd1};
            res.status = rjsc_pkg::ST_GAP;
          end else begin
            res.status = rjsc_pkg::ST_DISORDER;
          end
        end
        wr_mark  = seq17;
        wr_time  = beat.now_ms;
        byte_cnt = byte_cnt + 32'(beat.packet_length_in);
        pkt_cnt  = pkt_cnt + 32'd1;
      end
    end else begin
      res.status = rjsc_pkg::ST_NOTHING;
      cur        = rjsc_pkg::SEQ_NONE;
      if (wr_mark != rd_mark) begin
        if (rd_mark != rjsc_pkg::SEQ_NONE) cur = {1'b0, rd_mark[15:0] + 16'd1};
        else if (wr_mark != rjsc_pkg::SEQ_NONE) cur = wr_mark;
      end
      if (cur != rjsc_pkg::SEQ_NONE) begin
        pos  = cur[7:0];
        take = 1'b0;
        if (slot_full[pos]) begin
          take       = 1'b1;
          rd_time    = beat.now_ms;
          res.status = rjsc_pkg::ST_OK;
        end else if ((beat.now_ms - rd_time) > 32'(wait_limit)) begin
          // Skip the missing slot; the read time is not renewed.
          take = 1'b1;
          if (lost_cnt != 32'hFFFF_FFFF) lost_cnt = lost_cnt + 32'd1;
          res.status = rjsc_pkg::ST_LOST;
        end
        if (take) begin
          res.slot_index    = pos;
          res.packet_length = slot_len[pos];  // stale length on a skip
          res.read_seq      = cur[15:0];
          slot_full[pos]    = 1'b0;
          rd_mark           = cur;
        end
      end
    end
    res.lost_first     = gap_span[31:16];
    res.lost_last      = gap_span[15:0];
    res.lost_total     = lost_cnt;
    res.packets_stored = pkt_cnt;
    res.bytes_stored   = byte_cnt;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none or short, now and then long.
  // ---------------------------------------------------------------------------
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and the compare of every result beat.
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %0h actual %0h", name, want, got);
    end
  endfunction

  function automatic void check_slot_result(rjsc_pkg::out_t got);
    rjsc_pkg::out_t want;
    if (slot_results_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result beat with nothing pending: status %0d", got.status);
      return;
    end
    want = slot_results_due.pop_front();
    compare_field("status",         32'(want.status),     32'(got.status));
    compare_field("slot_index",     32'(want.slot_index), 32'(got.slot_index));
    compare_field("packet_length",  32'(want.packet_length), 32'(got.packet_length));
    compare_field("read_seq",       32'(want.read_seq),   32'(got.read_seq));
    compare_field("lost_first",     32'(want.lost_first), 32'(got.lost_first));
    compare_field("lost_last",      32'(want.lost_last),  32'(got.lost_last));
    compare_field("lost_total",     want.lost_total,      got.lost_total);
    compare_field("buffer_reset",   32'(want.buffer_reset), 32'(got.buffer_reset));
    compare_field("packets_stored", want.packets_stored,  got.packets_stored);
    compare_field("bytes_stored",   want.bytes_stored,    got.bytes_stored);
  endfunction

  int stall_left = 0;

  // Sampled at the edge, so values seen are the pre-edge ones the DUT also sees.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_slot_result(out_data);
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (!no_idle && out_ready && $urandom_range(0, 3) == 0) begin
        out_ready  <= 1'b0;
        stall_left <= pick_idle();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Called right after a rising edge. Valid stays high into the
  // next beat when no idle follows, so it is never dropped and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic send_beat(rjsc_pkg::in_t beat);
    int gap;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    slot_results_due.push_back(compute_slot_result(beat));
    gap = pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_write(logic [15:0] seq, logic [10:0] len, logic [31:0] now);
    rjsc_pkg::in_t beat;
    beat.opcode           = rjsc_pkg::OP_WRITE;
    beat.seq_number       = seq;
    beat.packet_length_in = len;
    beat.now_ms           = now;
    send_beat(beat);
  endtask

  // Sequence and length are don't-care on a read; they carry noise.
  task automatic send_read(logic [31:0] now);
    rjsc_pkg::in_t beat;
    beat.opcode           = rjsc_pkg::OP_READ;
    beat.seq_number       = 16'($urandom);
    beat.packet_length_in = 11'($urandom);
    beat.now_ms           = now;
    send_beat(beat);
  endtask

  // Wait until every predicted beat has come back, then let the pipe settle.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (slot_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One register write; the block is idle whenever this is called.
  task automatic program_register(logic [1:0] idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      rjsc_pkg::CFG_RESET_GAP: gap_limit = value;
      rjsc_pkg::CFG_LOST_WAIT: wait_limit = value;
      rjsc_pkg::CFG_MAX_LEN:   len_limit = value[10:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_limits(logic [15:0] gap, logic [15:0] wait_ms, logic [10:0] max_len);
    settle_block();
    program_register(rjsc_pkg::CFG_RESET_GAP, gap);
    program_register(rjsc_pkg::CFG_LOST_WAIT, wait_ms);
    program_register(rjsc_pkg::CFG_MAX_LEN, {5'd0, max_len});
  endtask

  // Mostly well-formed streams: writes near the next sequence, reads keeping
  // pace, time creeping forward with the odd jump past either limit.
  task automatic run_stream(int count);
    logic [15:0] next_seq;
    logic [15:0] seq;
    logic [10:0] len;
    logic [31:0] clock_ms;
    int          pick;
    int          stretch;
    next_seq = 16'($urandom);
    clock_ms = $urandom;
    stretch  = $urandom_range(20, 80);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) clock_ms = clock_ms + 32'(wait_limit) + $urandom_range(1, 3);
      else if (pick < 8) clock_ms = clock_ms + 32'(gap_limit) + $urandom_range(1, 4);
      else clock_ms = clock_ms + $urandom_range(0, 2);
      if ($urandom_range(0, 99) < 55) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          seq      = next_seq;
          next_seq = seq + 16'd1;
        end else if (pick < 90) begin
          seq      = next_seq + 16'($urandom_range(1, 6));   // leaves a gap
          next_seq = seq + 16'd1;
        end else begin
          seq = next_seq - 16'($urandom_range(1, 4));        // late or repeated
        end
        if ($urandom_range(0, 9) != 0) len = 11'($urandom_range(13, len_limit));
        else len = 11'($urandom_range(0, 2047));
        send_write(seq, len, clock_ms);
      end else begin
        send_read(clock_ms);
      end
      stretch--;
      if (stretch == 0) begin
        no_idle = !no_idle;
        stretch = $urandom_range(20, 80);
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked beats on the reset limits (gap 1000, wait 200, max 1400).
  task automatic test_directed_cases();
    send_read(32'd10);                       // no write seen yet
    send_write(16'd100, 11'd13, 32'd0);      // shortest legal, time stays unset
    send_write(16'd101, 11'd12, 32'd3);      // runt
    send_write(16'd101, 11'd1401, 32'd3);    // one over max
    send_write(16'd101, 11'd0, 32'd3);       // zero length
    send_write(16'd101, 11'd1400, 32'd3);    // exactly max, time set now
    send_write(16'd105, 11'd2047, 32'd3);    // all length bits set, oversize
    send_write(16'd105, 11'd500, 32'd4);     // gap 102..104
    send_write(16'd103, 11'd77, 32'd5);      // late
    send_write(16'd105, 11'd60, 32'd6);      // 105 again after the late 103: gap 104..104
    send_read(32'd7);                        // first read picks last written seq
    send_read(32'd8);                        // caught up
    send_write(16'd107, 11'd40, 32'd9);      // gap of one
    send_read(32'd207);                      // empty slot, wait exactly at limit
    send_read(32'd211);                      // past the wait: skipped as lost
    send_read(32'd212);
    send_write(16'hFFFF, 11'd100, 32'd300);  // wide gap up to 0xFFFE
    send_write(16'h0000, 11'd100, 32'd301);  // 16-bit wrap forgiven
    send_write(16'd1, 11'd200, 32'd1302);    // idle over 1000: buffer wipe
    send_read(32'd1303);
    send_write(16'd2, 11'd200, 32'd2302);    // idle exactly 1000: no wipe
    send_write(16'd3, 11'd300, 32'hFFFF_FFFF);
    send_write(16'd4, 11'd300, 32'd5);       // time wraps, short idle
    send_read(32'd6);
  endtask

  // Smallest limits: any idle wipes, any wait skips, only length 13 passes.
  task automatic test_tight_limits();
    apply_limits(16'd0, 16'd0, 11'd13);
    run_stream(120);
  endtask

  // Largest limits.
  task automatic test_wide_limits();
    apply_limits(16'hFFFF, 16'hFFFF, 11'd2047);
    run_stream(120);
  endtask

  // Several random settings with small times so wipes and skips happen often.
  task automatic test_random_settings();
    for (int p = 0; p < 6; p++) begin
      apply_limits(16'($urandom_range(20, 400)), 16'($urandom_range(5, 100)),
                   11'($urandom_range(13, 2047)));
      run_stream(120);
    end
  endtask

  // Unshaped beats: every field fully random.
  task automatic test_noise();
    rjsc_pkg::in_t beat;
    apply_limits(16'($urandom), 16'($urandom), 11'($urandom_range(13, 2047)));
    for (int i = 0; i < 150; i++) begin
      beat.opcode           = 1'($urandom);
      beat.seq_number       = 16'($urandom);
      beat.packet_length_in = 11'($urandom);
      beat.now_ms           = $urandom;
      send_beat(beat);
    end
  endtask

  initial begin
    wipe_slot_model();
    gap_span   = '0;
    gap_limit  = rjsc_pkg::RESET_GAP_DEFAULT;
    wait_limit = rjsc_pkg::LOST_WAIT_DEFAULT;
    len_limit  = rjsc_pkg::MAX_LEN_DEFAULT;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_tight_limits();
    test_wide_limits();
    test_random_settings();
    test_noise();

    settle_block();
    if (mismatch_count == 0 && slot_results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== rtp_jitter_slot_controller.f =====
sv/rjsc_pkg.sv
sv/rjsc_slot_mod.sv
sv/rtp_jitter_slot_controller.sv
tb/sv/tb_rtp_jitter_slot_controller.sv
